[rtl/pfk_pkg.sv]
package pfk_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int COEF_WIDTH  = 48;
   localparam int CSR_WIDTH   = 32;
   localparam int EXP_WIDTH   = 12;

   localparam int UNIT_STAGES = 16;
   localparam int UNIT_BITS   = 32 / UNIT_STAGES;
   localparam int FRONT_STAGES = 8;
   localparam int TAIL_STAGES  = 5;
   localparam int LATENCY = FRONT_STAGES + 2 * UNIT_STAGES + TAIL_STAGES;

   localparam logic [CSR_WIDTH-1:0] CUTOFF_RESET = 32'd589824;

   localparam logic [1:0] KIND_LJ         = 2'd0;
   localparam logic [1:0] KIND_REP        = 2'd1;
   localparam logic [1:0] KIND_SPRING     = 2'd2;
   localparam logic [1:0] KIND_SPRING_ALT = 2'd3;

   localparam logic [1:0] ST_APPLIED = 2'd0;
   localparam logic [1:0] ST_CUTOFF  = 2'd1;
   localparam logic [1:0] ST_SAT     = 2'd2;
   localparam logic [1:0] ST_ZERO    = 2'd3;

   typedef struct packed {
      logic [1:0]                    kind;
      logic signed [COORD_WIDTH-1:0] disp_x;
      logic signed [COORD_WIDTH-1:0] disp_y;
      logic signed [COORD_WIDTH-1:0] disp_z;
      logic [COEF_WIDTH-1:0]         coef_a;
      logic [COEF_WIDTH-1:0]         coef_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
      logic [1:0]         status;
   } rsp_type;

   // m * 2^e, m normalized to [2^31, 2^32) or zero
   typedef struct packed {
      logic [31:0]                 m;
      logic signed [EXP_WIDTH-1:0] e;
   } fnum_type;

   typedef struct packed {
      logic              harm;
      logic              rep;
      logic              zero;
      logic              beyond;
      logic [2:0]        xneg;
      fnum_type [2:0]    nmag;
      fnum_type          a;
      fnum_type          b;
      fnum_type          ab;
      fnum_type          s;
      fnum_type          s2;
      fnum_type          s4;
      fnum_type          s6;
      fnum_type          s7;
   } carry_type;

   function automatic logic [5:0] msb64(input logic [63:0] v);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) p = 6'(i);
      end
      return p;
   endfunction

   function automatic fnum_type norm64(input logic [63:0] v,
                                       input logic signed [EXP_WIDTH-1:0] q);
      fnum_type r;
      logic [5:0] p;
      logic [63:0] sh;
      p = msb64(v);
      sh = v << (6'd63 - p);
      r.m = sh[63:32];
      r.e = q + $signed({6'b0, p}) - 12'sd31;
      if (v == '0) r = '0;
      return r;
   endfunction

   function automatic fnum_type fmul(input fnum_type a, input fnum_type b);
      fnum_type r;
      logic [63:0] p;
      p = a.m * b.m;
      if (p[63]) begin
         r.m = p[63:32];
         r.e = a.e + b.e + 12'sd32;
      end else begin
         r.m = p[62:31];
         r.e = a.e + b.e + 12'sd31;
      end
      if (a.m == '0 || b.m == '0) r = '0;
      return r;
   endfunction

   // {saturated, Q16.16 value}
   function automatic logic [32:0] to_fixed(input fnum_type v, input logic neg);
      logic signed [EXP_WIDTH:0] k;
      logic [63:0] mag;
      logic [63:0] limit;
      logic        sat;
      logic [31:0] val;
      k = (EXP_WIDTH+1)'(v.e) + 13'sd16;
      limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      mag = '0;
      if (v.m != '0) begin
         if (k >= 13'sd32) mag = limit + 64'd1;
         else if (k >= 13'sd0) mag = {32'b0, v.m} << k[4:0];
         else if (k > -13'sd64) mag = {32'b0, v.m} >> 6'(-k);
      end
      sat = mag > limit;
      if (sat) mag = limit;
      val = neg ? (~mag[31:0] + 32'd1) : mag[31:0];
      return {sat, val};
   endfunction

endpackage

[rtl/pfk_sqrt.sv]
module pfk_sqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  pfk_pkg::fnum_type  in_num,
   output logic               out_valid,
   output pfk_pkg::fnum_type  out_num
);

   localparam int STAGES = pfk_pkg::UNIT_STAGES;

   logic                                 v_ff    [STAGES];
   logic [35:0]                          rem_ff  [STAGES];
   logic [31:0]                          root_ff [STAGES];
   logic [63:0]                          w_ff    [STAGES];
   logic signed [pfk_pkg::EXP_WIDTH-1:0] e_ff    [STAGES];

   logic [35:0]                          rem_in  [STAGES];
   logic [31:0]                          root_in [STAGES];
   logic [63:0]                          w_in    [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic                                 v_src;
      logic [35:0]                          rem_src;
      logic [31:0]                          root_src;
      logic [63:0]                          w_src;
      logic signed [pfk_pkg::EXP_WIDTH-1:0] e_src;

      if (s == 0) begin : g_first
         logic signed [pfk_pkg::EXP_WIDTH-1:0] ew;
         assign ew       = in_num.e[0] ? (in_num.e - 12'sd31) : (in_num.e - 12'sd32);
         assign v_src    = in_valid;
         assign rem_src  = '0;
         assign root_src = '0;
         assign w_src    = in_num.e[0] ? {1'b0, in_num.m, 31'b0} : {in_num.m, 32'b0};
         assign e_src    = ew >>> 1;
      end else begin : g_next
         assign v_src    = v_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
         assign w_src    = w_ff[s-1];
         assign e_src    = e_ff[s-1];
      end

      always_comb begin
         logic [35:0] rem;
         logic [35:0] trial;
         logic [31:0] root;
         logic [63:0] w;
         rem  = rem_src;
         root = root_src;
         w    = w_src;
         for (int i = 0; i < pfk_pkg::UNIT_BITS; i++) begin
            rem   = {rem[33:0], w[63:62]};
            w     = {w[61:0], 2'b00};
            trial = {2'b00, root, 2'b01};
            if (rem >= trial) begin
               rem  = rem - trial;
               root = {root[30:0], 1'b1};
            end else begin
               root = {root[30:0], 1'b0};
            end
         end
         rem_in[s]  = rem;
         root_in[s] = root;
         w_in[s]    = w;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else begin
            v_ff[s] <= v_src;
         end
         rem_ff[s]  <= rem_in[s];
         root_ff[s] <= root_in[s];
         w_ff[s]    <= w_in[s];
         e_ff[s]    <= e_src;
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_num   = '{m: root_ff[STAGES-1], e: e_ff[STAGES-1]};

endmodule

[rtl/pfk_recip.sv]
module pfk_recip (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  pfk_pkg::fnum_type  in_num,
   output logic               out_valid,
   output pfk_pkg::fnum_type  out_num
);

   localparam int STAGES = pfk_pkg::UNIT_STAGES;

   logic                                 v_ff   [STAGES];
   logic [32:0]                          rem_ff [STAGES];
   logic [31:0]                          q_ff   [STAGES];
   logic [31:0]                          d_ff   [STAGES];
   logic signed [pfk_pkg::EXP_WIDTH-1:0] e_ff   [STAGES];
   logic                                 pow_ff [STAGES];

   logic [32:0]                          rem_in [STAGES];
   logic [31:0]                          q_in   [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic                                 v_src;
      logic [32:0]                          rem_src;
      logic [31:0]                          q_src;
      logic [31:0]                          d_src;
      logic signed [pfk_pkg::EXP_WIDTH-1:0] e_src;
      logic                                 pow_src;

      if (s == 0) begin : g_first
         assign v_src   = in_valid;
         assign rem_src = 33'h0_8000_0000;
         assign q_src   = '0;
         assign d_src   = in_num.m;
         assign pow_src = in_num.m == 32'h8000_0000;
         assign e_src   = pow_src ? (-12'sd62 - in_num.e) : (-12'sd63 - in_num.e);
      end else begin : g_next
         assign v_src   = v_ff[s-1];
         assign rem_src = rem_ff[s-1];
         assign q_src   = q_ff[s-1];
         assign d_src   = d_ff[s-1];
         assign pow_src = pow_ff[s-1];
         assign e_src   = e_ff[s-1];
      end

      always_comb begin
         logic [32:0] rem;
         logic [31:0] q;
         rem = rem_src;
         q   = q_src;
         for (int i = 0; i < pfk_pkg::UNIT_BITS; i++) begin
            rem = {rem[31:0], 1'b0};
            if (rem >= {1'b0, d_src}) begin
               rem = rem - {1'b0, d_src};
               q   = {q[30:0], 1'b1};
            end else begin
               q   = {q[30:0], 1'b0};
            end
         end
         rem_in[s] = rem;
         q_in[s]   = q;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else begin
            v_ff[s] <= v_src;
         end
         rem_ff[s] <= rem_in[s];
         q_ff[s]   <= q_in[s];
         d_ff[s]   <= d_src;
         e_ff[s]   <= e_src;
         pow_ff[s] <= pow_src;
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_num   = '{m: (pow_ff[STAGES-1] ? 32'h8000_0000 : q_ff[STAGES-1]),
                        e: e_ff[STAGES-1]};

endmodule

[rtl/pfk_delay.sv]
module pfk_delay (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  pfk_pkg::carry_type  in_data,
   output logic                out_valid,
   output pfk_pkg::carry_type  out_data
);

   localparam int STAGES = pfk_pkg::UNIT_STAGES;

   logic               v_ff [STAGES];
   pfk_pkg::carry_type d_ff [STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) v_ff[i] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < STAGES; i++) v_ff[i] <= v_ff[i-1];
      end
      d_ff[0] <= in_data;
      for (int i = 1; i < STAGES; i++) d_ff[i] <= d_ff[i-1];
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_data  = d_ff[STAGES-1];

endmodule

[rtl/pair_force_kernel.sv]
// Pair force kernel: force on atom B of one atom pair, Q16.16 out.
//
// Request channel: a transaction is taken at each rising edge with start high
// and busy low. busy stays low, so a new pair may be issued every cycle.
// req_data carries kind, displacement B minus A and the two coefficients.
// Result channel: rsp_strobe is high for one cycle with rsp_data; the
// receiver cannot stall, so no backpressure exists anywhere in the pipe.
// csr_we / csr_wdata write the squared cutoff (unsigned Q16.16); write it
// only while no transaction is in flight.
// Pipeline: 8 front stages (capture, squares, sum and cutoff test, normalize,
// powers of |r|^2), a 16 stage square root, a 16 stage reciprocal (2 quotient
// bits per stage), then 5 stages for the terms, difference, normalize, scale
// and fixed point conversion.
// Throughput: one pair per cycle.
// Reset: clears all valid bits and sets the cutoff to 9.0; pairs in flight
// are dropped.
module pair_force_kernel (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  pfk_pkg::req_type                  req_data,
   output logic                              rsp_strobe,
   output pfk_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [pfk_pkg::CSR_WIDTH-1:0]     csr_wdata
);

   localparam int CW = pfk_pkg::COORD_WIDTH;

   logic [pfk_pkg::CSR_WIDTH-1:0] cutoff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= pfk_pkg::CUTOFF_RESET;
      end else if (csr_we) begin
         cutoff_ff <= csr_wdata;
      end
   end

   assign busy = 1'b0;

   // stage 1: capture
   logic             v1_ff;
   pfk_pkg::req_type req1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
      req1_ff <= req_data;
   end

   // stage 2: magnitudes and squares
   logic [CW-1:0]   disp [3];
   logic            v2_ff;
   logic [1:0]      kind2_ff;
   logic [pfk_pkg::COEF_WIDTH-1:0] a2_ff, b2_ff;
   logic [CW-1:0]   mag2_ff [3];
   logic [2:0]      xneg2_ff;
   logic [2*CW-1:0] sq2_ff [3];

   assign disp[0] = req1_ff.disp_x;
   assign disp[1] = req1_ff.disp_y;
   assign disp[2] = req1_ff.disp_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      kind2_ff <= req1_ff.kind;
      a2_ff    <= req1_ff.coef_a;
      b2_ff    <= req1_ff.coef_b;
      for (int i = 0; i < 3; i++) begin
         logic [CW-1:0] m;
         m = disp[i][CW-1] ? (~disp[i] + CW'(1)) : disp[i];
         mag2_ff[i]  <= m;
         xneg2_ff[i] <= disp[i][CW-1];
         sq2_ff[i]   <= m * m;
      end
   end

   // stage 3: squared distance, cutoff test
   logic          v3_ff;
   logic [1:0]    kind3_ff;
   logic [pfk_pkg::COEF_WIDTH-1:0] a3_ff, b3_ff;
   logic [CW-1:0] mag3_ff [3];
   logic [2:0]    xneg3_ff;
   logic [63:0]   s3_ff;
   logic          zero3_ff, beyond3_ff;
   logic [63:0]   s3_in;

   assign s3_in = sq2_ff[0] + sq2_ff[1] + sq2_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      kind3_ff   <= kind2_ff;
      a3_ff      <= a2_ff;
      b3_ff      <= b2_ff;
      mag3_ff    <= mag2_ff;
      xneg3_ff   <= xneg2_ff;
      s3_ff      <= s3_in;
      zero3_ff   <= s3_in == '0;
      beyond3_ff <= !kind2_ff[1] && !(s3_in < {16'b0, cutoff_ff, 16'b0});
   end

   // stages 4..8: normalize, then powers of |r|^2 and the product a*b
   logic               v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   pfk_pkg::carry_type c4_ff, c5_ff, c6_ff, c7_ff, c8_ff;
   pfk_pkg::carry_type c4_in, c5_in, c6_in, c7_in, c8_in;

   always_comb begin
      c4_in        = '0;
      c4_in.harm   = kind3_ff[1];
      c4_in.rep    = kind3_ff == pfk_pkg::KIND_REP;
      c4_in.zero   = zero3_ff;
      c4_in.beyond = beyond3_ff;
      c4_in.xneg   = xneg3_ff;
      for (int i = 0; i < 3; i++) begin
         c4_in.nmag[i] = pfk_pkg::norm64({32'b0, mag3_ff[i]}, -12'sd16);
      end
      c4_in.a = pfk_pkg::norm64({16'b0, a3_ff}, -12'sd24);
      c4_in.b = pfk_pkg::norm64({16'b0, b3_ff}, -12'sd24);
      c4_in.s = pfk_pkg::norm64(s3_ff, -12'sd32);
   end

   always_comb begin
      c5_in    = c4_ff;
      c5_in.s2 = pfk_pkg::fmul(c4_ff.s, c4_ff.s);
      c5_in.ab = pfk_pkg::fmul(c4_ff.a, c4_ff.b);
      c6_in    = c5_ff;
      c6_in.s4 = pfk_pkg::fmul(c5_ff.s2, c5_ff.s2);
      c7_in    = c6_ff;
      c7_in.s6 = pfk_pkg::fmul(c6_ff.s4, c6_ff.s2);
      c8_in    = c7_ff;
      c8_in.s7 = pfk_pkg::fmul(c7_ff.s6, c7_ff.s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
      c4_ff <= c4_in;
      c5_ff <= c5_in;
      c6_ff <= c6_in;
      c7_ff <= c7_in;
      c8_ff <= c8_in;
   end

   // square root with the item record alongside
   logic               sq_valid, d1_valid;
   pfk_pkg::fnum_type  sq_num;
   pfk_pkg::carry_type d1_data;

   pfk_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v8_ff),
      .in_num    (c8_ff.s),
      .out_valid (sq_valid),
      .out_num   (sq_num)
   );

   pfk_delay u_delay_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v8_ff),
      .in_data   (c8_ff),
      .out_valid (d1_valid),
      .out_data  (d1_data)
   );

   // reciprocals: 1/|r| or 1/|r|^14, and 1/|r|^8
   logic               r1_valid, r2_valid, d2_valid;
   pfk_pkg::fnum_type  r1_num, r2_num;
   pfk_pkg::carry_type d2_data;

   pfk_recip u_recip_main (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_num    (d1_data.harm ? sq_num : d1_data.s7),
      .out_valid (r1_valid),
      .out_num   (r1_num)
   );

   pfk_recip u_recip_attr (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d1_valid),
      .in_num    (d1_data.s4),
      .out_valid (r2_valid),
      .out_num   (r2_num)
   );

   pfk_delay u_delay_recip (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d1_valid),
      .in_data   (d1_data),
      .out_valid (d2_valid),
      .out_data  (d2_data)
   );

   // terms
   logic               vt_ff;
   pfk_pkg::carry_type ct_ff;
   pfk_pkg::fnum_type  t1_ff, t2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vt_ff <= 1'b0;
      end else begin
         vt_ff <= r1_valid && r2_valid && d2_valid;
      end
      ct_ff <= d2_data;
      t1_ff <= pfk_pkg::fmul(d2_data.harm ? d2_data.ab : d2_data.a, r1_num);
      if (d2_data.harm) begin
         t2_ff <= d2_data.a;
      end else if (d2_data.rep) begin
         t2_ff <= '0;
      end else begin
         t2_ff <= pfk_pkg::fmul(d2_data.b, r2_num);
      end
   end

   // difference, aligned
   logic                                 vd_ff;
   pfk_pkg::carry_type                   cd_ff;
   logic [63:0]                          diff_ff;
   logic signed [pfk_pkg::EXP_WIDTH-1:0] dexp_ff;
   logic                                 cneg_d_ff;
   logic                                 ge;
   pfk_pkg::fnum_type                    big, lit;
   logic signed [pfk_pkg::EXP_WIDTH-1:0] gap;
   logic [63:0]                          m2;

   always_comb begin
      if (t2_ff.m == '0) ge = 1'b1;
      else if (t1_ff.m == '0) ge = 1'b0;
      else if (t1_ff.e != t2_ff.e) ge = t1_ff.e > t2_ff.e;
      else ge = t1_ff.m >= t2_ff.m;
      big = ge ? t1_ff : t2_ff;
      lit = ge ? t2_ff : t1_ff;
      gap = big.e - lit.e;
      m2  = '0;
      if (lit.m != '0 && gap < 12'sd63) m2 = {1'b0, lit.m, 31'b0} >> gap[5:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else begin
         vd_ff <= vt_ff;
      end
      cd_ff     <= ct_ff;
      cneg_d_ff <= !ge;
      diff_ff   <= (big.m == '0) ? 64'd0 : ({1'b0, big.m, 31'b0} - m2);
      dexp_ff   <= big.e - 12'sd31;
   end

   // normalize coefficient
   logic               vn_ff;
   pfk_pkg::carry_type cn_ff;
   pfk_pkg::fnum_type  coef_ff;
   logic               cneg_n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vn_ff <= 1'b0;
      end else begin
         vn_ff <= vd_ff;
      end
      cn_ff     <= cd_ff;
      coef_ff   <= pfk_pkg::norm64(diff_ff, dexp_ff);
      cneg_n_ff <= cneg_d_ff;
   end

   // scale by each component
   logic                   vf_ff;
   logic                   zero_f_ff, beyond_f_ff;
   pfk_pkg::fnum_type [2:0] f_ff;
   logic [2:0]             neg_f_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= 1'b0;
      end else begin
         vf_ff <= vn_ff;
      end
      zero_f_ff   <= cn_ff.zero;
      beyond_f_ff <= cn_ff.beyond;
      for (int i = 0; i < 3; i++) begin
         f_ff[i]     <= pfk_pkg::fmul(coef_ff, cn_ff.nmag[i]);
         neg_f_ff[i] <= cneg_n_ff ^ cn_ff.xneg[i];
      end
   end

   // fixed point, status
   logic             rsp_strobe_ff;
   pfk_pkg::rsp_type rsp_data_ff;
   pfk_pkg::rsp_type rsp_data_in;
   logic [32:0]      fx [3];

   always_comb begin
      for (int i = 0; i < 3; i++) fx[i] = pfk_pkg::to_fixed(f_ff[i], neg_f_ff[i]);
      rsp_data_in = '0;
      if (zero_f_ff) begin
         rsp_data_in.status = pfk_pkg::ST_ZERO;
      end else if (beyond_f_ff) begin
         rsp_data_in.status = pfk_pkg::ST_CUTOFF;
      end else begin
         rsp_data_in.force_x = fx[0][31:0];
         rsp_data_in.force_y = fx[1][31:0];
         rsp_data_in.force_z = fx[2][31:0];
         rsp_data_in.status  = (fx[0][32] || fx[1][32] || fx[2][32]) ?
                               pfk_pkg::ST_SAT : pfk_pkg::ST_APPLIED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= vf_ff;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

[rtl/pfk_checker.sv]
module pfk_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input pfk_pkg::rsp_type rsp_data
);

   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, pfk_pkg::LATENCY))
      else $error("result without a transaction");

   a_txn_delivered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(pfk_pkg::LATENCY) rsp_strobe)
      else $error("transaction lost");

   a_zero_dist: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == pfk_pkg::ST_ZERO) |->
      (rsp_data.force_x == 0 && rsp_data.force_y == 0 && rsp_data.force_z == 0))
      else $error("zero distance with nonzero force");

   a_cutoff: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == pfk_pkg::ST_CUTOFF) |->
      (rsp_data.force_x == 0 && rsp_data.force_y == 0 && rsp_data.force_z == 0))
      else $error("beyond cutoff with nonzero force");

endmodule

bind pair_force_kernel pfk_checker u_pfk_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

[tb/sv/pair_force_kernel_tb.sv]
module pair_force_kernel_tb;
   import pfk_pkg::*;

   typedef struct {
      logic [31:0] m;
      int          e;
   } flt_type;

   class force_scoreboard;
      rsp_type                expected_q[$];
      logic [CSR_WIDTH-1:0]   cutoff;
      int                     mismatches;

      function new();
         cutoff = CUTOFF_RESET;
         mismatches = 0;
      endfunction

      function flt_type to_flt(logic [127:0] v, int q);
         flt_type r;
         int p;
         r.m = '0;
         r.e = 0;
         if (v == '0) return r;
         p = 0;
         for (int i = 0; i < 128; i++) if (v[i]) p = i;
         if (p >= 31) r.m = 32'(v >> (p - 31));
         else r.m = 32'(v << (31 - p));
         r.e = q + p - 31;
         return r;
      endfunction

      function flt_type mul(flt_type a, flt_type b);
         flt_type r;
         logic [63:0] p;
         r.m = '0;
         r.e = 0;
         if (a.m == '0 || b.m == '0) return r;
         p = {32'b0, a.m} * {32'b0, b.m};
         if (p[63]) begin
            r.m = p[63:32];
            r.e = a.e + b.e + 32;
         end else begin
            r.m = p[62:31];
            r.e = a.e + b.e + 31;
         end
         return r;
      endfunction

      function flt_type recip(flt_type a);
         flt_type r;
         logic [63:0] q;
         q = 64'h8000_0000_0000_0000 / {32'b0, a.m};
         if (q[63:32] != '0) begin
            r.m = 32'h8000_0000;
            r.e = -62 - a.e;
         end else begin
            r.m = q[31:0];
            r.e = -63 - a.e;
         end
         return r;
      endfunction

      function flt_type root(flt_type a);
         flt_type r;
         logic [63:0] w, res, bitv;
         int ew;
         if ((a.e % 2) == 0) begin
            w = {a.m, 32'b0};
            ew = a.e - 32;
         end else begin
            w = {1'b0, a.m, 31'b0};
            ew = a.e - 31;
         end
         res = '0;
         bitv = 64'h4000_0000_0000_0000;
         while (bitv != '0) begin
            if (w >= res + bitv) begin
               w = w - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         r.m = res[31:0];
         r.e = ew / 2;
         return r;
      endfunction

      function flt_type diff(flt_type a, flt_type b, output logic neg);
         flt_type big, lit;
         logic [63:0] m1, m2;
         int d;
         logic a_ge;
         if (b.m == '0) a_ge = 1'b1;
         else if (a.m == '0) a_ge = 1'b0;
         else if (a.e != b.e) a_ge = a.e > b.e;
         else a_ge = a.m >= b.m;
         if (a_ge) begin
            big = a; lit = b; neg = 1'b0;
         end else begin
            big = b; lit = a; neg = 1'b1;
         end
         if (big.m == '0) return big;
         m1 = {1'b0, big.m, 31'b0};
         m2 = '0;
         d = big.e - lit.e;
         if (lit.m != '0 && d < 63) m2 = {1'b0, lit.m, 31'b0} >> d;
         return to_flt({64'b0, m1 - m2}, big.e - 31);
      endfunction

      function logic [31:0] fix(flt_type v, logic neg, inout logic sat);
         logic [63:0] lim, mag;
         int k;
         lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
         mag = '0;
         k = v.e + 16;
         if (v.m != '0) begin
            if (k >= 32) mag = lim + 1;
            else if (k >= 0) mag = {32'b0, v.m} << k;
            else if (-k < 64) mag = {32'b0, v.m} >> (-k);
         end
         if (mag > lim) begin
            mag = lim;
            sat = 1'b1;
         end
         return neg ? (~mag[31:0] + 32'd1) : mag[31:0];
      endfunction

      function rsp_type pair_force(req_type r);
         rsp_type o;
         logic [31:0] d[3], mag[3];
         logic        xneg[3];
         logic [127:0] dist_sq;
         logic        harm, cneg, sat;
         flt_type s, a, b, t1, t2, c, s2, s4;
         d[0] = r.disp_x;
         d[1] = r.disp_y;
         d[2] = r.disp_z;
         dist_sq = '0;
         for (int i = 0; i < 3; i++) begin
            xneg[i] = d[i][31];
            mag[i] = xneg[i] ? (~d[i] + 32'd1) : d[i];
            dist_sq = dist_sq + {96'b0, mag[i]} * {96'b0, mag[i]};
         end
         o = '0;
         if (dist_sq == '0) begin
            o.status = ST_ZERO;
            return o;
         end
         harm = r.kind[1];
         if (!harm && !(dist_sq < {80'b0, cutoff, 16'b0})) begin
            o.status = ST_CUTOFF;
            return o;
         end
         s = to_flt(dist_sq, -32);
         a = to_flt({80'b0, r.coef_a}, -24);
         b = to_flt({80'b0, r.coef_b}, -24);
         if (harm) begin
            t1 = mul(mul(a, b), recip(root(s)));
            t2 = a;
         end else begin
            s2 = mul(s, s);
            s4 = mul(s2, s2);
            t1 = mul(a, recip(mul(mul(s4, s2), s)));
            if (r.kind == KIND_REP) begin
               t2.m = '0;
               t2.e = 0;
            end else begin
               t2 = mul(b, recip(s4));
            end
         end
         c = diff(t1, t2, cneg);
         sat = 1'b0;
         o.force_x = fix(mul(c, to_flt({96'b0, mag[0]}, -16)), cneg != xneg[0], sat);
         o.force_y = fix(mul(c, to_flt({96'b0, mag[1]}, -16)), cneg != xneg[1], sat);
         o.force_z = fix(mul(c, to_flt({96'b0, mag[2]}, -16)), cneg != xneg[2], sat);
         o.status = sat ? ST_SAT : ST_APPLIED;
         return o;
      endfunction

      function void note_pair(req_type r);
         expected_q.push_back(pair_force(r));
      endfunction

      function void check_force(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         want = expected_q.pop_front();
         if (got.force_x !== want.force_x || got.force_y !== want.force_y ||
             got.force_z !== want.force_z || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_we;
   logic [CSR_WIDTH-1:0] csr_wdata;

   force_scoreboard sb;
   int quiet_cycles;

   pair_force_kernel dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_force(rsp_data);
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 3000) begin
         $display("pair_force_kernel_tb failed");
         $finish;
      end
   end

   function automatic req_type mk_pair(logic [1:0] k, logic [31:0] x, logic [31:0] y,
                                       logic [31:0] z, logic [47:0] a, logic [47:0] b);
      req_type r;
      r.kind = k;
      r.disp_x = x;
      r.disp_y = y;
      r.disp_z = z;
      r.coef_a = a;
      r.coef_b = b;
      return r;
   endfunction

   function automatic logic [31:0] rnd_coord();
      logic [31:0] v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = $urandom_range(0, 196608);
         2: v = $urandom_range(0, 4096);
         default: begin
            case ($urandom_range(0, 4))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'd1;
               3: v = 32'hFFFF_FFFF;
               default: v = '0;
            endcase
         end
      endcase
      if ($urandom_range(0, 1)) v = ~v + 32'd1;
      return v;
   endfunction

   function automatic logic [47:0] rnd_coef();
      logic [63:0] t;
      t = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0: return t[47:0];
         1: return t[47:0] >> $urandom_range(0, 47);
         2: return 48'(t[7:0]) << 24;
         3: return '0;
         default: return t[47:0] >> $urandom_range(16, 40);
      endcase
   endfunction

   task automatic send_pair(req_type r, bit burst);
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_pair(r);
      if (!burst && $urandom_range(0, 99) < 36) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   task automatic drain_and_set(logic [CSR_WIDTH-1:0] value);
      start <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      sb.cutoff = value;
      csr_we <= 1'b0;
   endtask

   task automatic directed_pairs();
      localparam logic [47:0] ONE = 48'h100_0000;
      for (int k = 0; k < 4; k++) send_pair(mk_pair(2'(k), 0, 0, 0, ONE, ONE), 0);
      send_pair(mk_pair(KIND_LJ, 32'h1_0000, 0, 0, ONE, ONE), 0);
      send_pair(mk_pair(KIND_LJ, 32'h1_0000, 0, 0, ONE, 48'hFFFF_FFFF_FFFF), 0);
      send_pair(mk_pair(KIND_REP, 0, 32'h1_8000, 0, ONE, ONE), 0);
      send_pair(mk_pair(KIND_SPRING, 32'h2_0000, 0, 0, 2 * ONE, ONE), 0);
      send_pair(mk_pair(KIND_SPRING_ALT, 32'h2_0000, 0, 0, 2 * ONE, ONE), 0);
      send_pair(mk_pair(KIND_LJ, 32'd1, 0, 0, 48'hFFFF_FFFF_FFFF, 48'd0), 0);
      send_pair(mk_pair(KIND_REP, 32'd1, 32'hFFFF_FFFF, 32'd1, 48'hFFFF_FFFF_FFFF, 48'd0), 0);
      send_pair(mk_pair(KIND_LJ, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, ONE, ONE), 0);
      send_pair(mk_pair(KIND_LJ, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, ONE, ONE), 0);
      send_pair(mk_pair(KIND_SPRING, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        48'hFFFF_FFFF_FFFF, 48'd0), 0);
      send_pair(mk_pair(KIND_SPRING, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1,
                        48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF), 0);
      send_pair(mk_pair(KIND_SPRING, 32'd1, 32'd1, 32'd1, ONE, 48'hFFFF_FFFF_FFFF), 0);
      send_pair(mk_pair(KIND_LJ, 32'h1_4000, 32'hFFFF_0000, 0, 48'd0, 48'd0), 0);
      send_pair(mk_pair(KIND_REP, 32'hFFFE_C000, 0, 32'h1_0000, 48'd0, ONE), 0);
   endtask

   task automatic random_pairs(int n, bit burst);
      for (int i = 0; i < n; i++)
         send_pair(mk_pair(2'($urandom_range(0, 3)), rnd_coord(), rnd_coord(), rnd_coord(),
                           rnd_coef(), rnd_coef()), burst);
   endtask

   initial begin
      sb = new();
      quiet_cycles = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      directed_pairs();
      random_pairs(200, 0);
      drain_and_set('0);
      random_pairs(100, 0);
      drain_and_set(32'hFFFF_FFFF);
      directed_pairs();
      random_pairs(150, 0);
      drain_and_set(32'h1_0000);
      random_pairs(150, 0);
      drain_and_set($urandom);
      random_pairs(150, 1);
      drain_and_set(CUTOFF_RESET);
      random_pairs(120, 0);
      start <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (sb.mismatches == 0) $display("pair_force_kernel_tb passed");
      else $display("pair_force_kernel_tb failed");
      $finish;
   end

endmodule

[filelist.f]
rtl/pfk_pkg.sv
rtl/pfk_sqrt.sv
rtl/pfk_recip.sv
rtl/pfk_delay.sv
rtl/pair_force_kernel.sv
rtl/pfk_checker.sv
tb/sv/pair_force_kernel_tb.sv
